[rtl/dmxfr_pkg.sv]
// Package for the DMX frame receiver and slot reader.
// Holds sizing constants, result codes, FSM state type and control structs.
// No dependencies; dmxfr_ctrl, dmxfr_dp and the top level use it.
package dmxfr_pkg;

  // Sizing
  localparam int MAX_CHANNELS     = 248;
  localparam int MAX_PACKET_BYTES = 250;
  localparam int SLOT_BYTES       = 4;

  localparam int COUNT_CAP  = MAX_PACKET_BYTES + 1;
  localparam int BANK_DEPTH = 2 * MAX_CHANNELS;
  localparam int ADDR_W     = $clog2(BANK_DEPTH);
  localparam int CNT_W      = 9;
  localparam int SLOT_W     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SLOT   = 1'b1;

  // Input modes
  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE     = 3'd2;
  localparam logic [2:0] ST_ZERO_START   = 3'd3;
  localparam logic [2:0] ST_ADDR_ZERO    = 3'd4;
  localparam logic [2:0] ST_NO_FRAME     = 3'd5;
  localparam logic [2:0] ST_BEFORE_START = 3'd6;
  localparam logic [2:0] ST_PAST_END     = 3'd7;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;   // accept a packet byte
    logic read_start;  // accept a read request, latch its check
    logic read_issue;  // launch a frame store read for the current slot byte
    logic read_emit;   // load the slot byte into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a beat this cycle
    logic slot_last;   // current slot byte is the last of the request
  } dp_status_t;

endpackage

[rtl/dmxfr_in_if.sv]
// Input channel of the DMX frame receiver: valid/ready plus one item.
// Depends on nothing.
interface dmxfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] packet_byte;
  logic       packet_end;
  logic [7:0] read_address;

  modport source (output valid, mode, packet_byte, packet_end, read_address,
                  input ready);
  modport sink   (input valid, mode, packet_byte, packet_end, read_address,
                  output ready);
endinterface

[rtl/dmxfr_out_if.sv]
// Result channel of the DMX frame receiver: valid/ready plus one result.
// Depends on nothing.
interface dmxfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] status;
  logic [7:0] value_byte;
  logic       run_last;

  modport source (output valid, kind, status, value_byte, run_last,
                  input ready);
  modport sink   (input valid, kind, status, value_byte, run_last,
                  output ready);
endinterface

[rtl/dmxfr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module dmxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dmxfr_ctrl.sv]
// Controller FSM for the DMX frame receiver: input handshake and slot read
// sequencing. Depends on dmxfr_pkg.
module dmxfr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_mode_i,
  output logic                   in_ready_o,
  input  dmxfr_pkg::dp_status_t  status_i,
  output dmxfr_pkg::ctrl_cmd_t   cmd_o
);

  dmxfr_pkg::state_e state_q, state_d;
  logic              accept;

  assign in_ready_o = (state_q == dmxfr_pkg::S_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      dmxfr_pkg::S_IDLE: begin
        if (accept) begin
          if (in_mode_i == dmxfr_pkg::MODE_PACKET) begin
            cmd_o.take_byte = 1'b1;
          end else begin
            cmd_o.read_start = 1'b1;
            state_d          = dmxfr_pkg::S_RD;
          end
        end
      end
      dmxfr_pkg::S_RD: begin
        cmd_o.read_issue = 1'b1;
        state_d          = dmxfr_pkg::S_OUT;
      end
      dmxfr_pkg::S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.read_emit = 1'b1;
          state_d = status_i.slot_last ? dmxfr_pkg::S_IDLE : dmxfr_pkg::S_RD;
        end
      end
      default: begin
        state_d = dmxfr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmxfr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/dmxfr_dp.sv]
// Datapath for the DMX frame receiver: byte counter, packet check, bank
// swap, read check, frame store and output register.
// Depends on dmxfr_pkg, dmxfr_ram and the two channel interfaces.
module dmxfr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dmxfr_in_if.sink              in_i,
  dmxfr_out_if.source           out_o,
  input  dmxfr_pkg::ctrl_cmd_t  cmd_i,
  output dmxfr_pkg::dp_status_t status_o
);

  localparam logic [dmxfr_pkg::CNT_W-1:0] MaxCh =
    dmxfr_pkg::CNT_W'(dmxfr_pkg::MAX_CHANNELS);
  localparam logic [dmxfr_pkg::CNT_W-1:0] MaxPkt =
    dmxfr_pkg::CNT_W'(dmxfr_pkg::MAX_PACKET_BYTES);
  localparam logic [dmxfr_pkg::CNT_W-1:0] Cap =
    dmxfr_pkg::CNT_W'(dmxfr_pkg::COUNT_CAP);
  localparam logic [dmxfr_pkg::CNT_W-1:0] Slot =
    dmxfr_pkg::CNT_W'(dmxfr_pkg::SLOT_BYTES);
  localparam logic [dmxfr_pkg::SLOT_W-1:0] SlotLast =
    dmxfr_pkg::SLOT_W'(dmxfr_pkg::SLOT_BYTES - 1);

  // Frame and packet state
  logic                          active_bank_q;
  logic [7:0]                    active_size_q, active_start_q;
  logic [7:0]                    pending_size_q, pending_start_q;
  logic [dmxfr_pkg::CNT_W-1:0]   byte_count_q;

  // Read request state
  logic [2:0]                    rd_status_q;
  logic [dmxfr_pkg::ADDR_W-1:0]  rd_base_q;
  logic [dmxfr_pkg::SLOT_W-1:0]  slot_k_q;

  // Output register
  logic                          out_valid_q;
  logic                          out_kind_q, out_last_q;
  logic [2:0]                    out_status_q;
  logic [7:0]                    out_value_q;

  // Combinational
  logic [dmxfr_pkg::CNT_W-1:0]   pay_off, len;
  logic [7:0]                    psize, pstart;
  logic [2:0]                    pkt_status;
  logic                          wr_en;
  logic [dmxfr_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
  logic [7:0]                    rd_data;
  logic [2:0]                    req_status;
  logic [7:0]                    req_off;
  logic                          pkt_done;

  assign status_o.out_free  = !out_valid_q || out_o.ready;
  assign status_o.slot_last = (slot_k_q == SlotLast);

  // Packet byte: offset into payload, saturated length, size/start view
  assign pay_off  = byte_count_q - dmxfr_pkg::CNT_W'(2);
  assign len      = (byte_count_q < Cap) ? byte_count_q + dmxfr_pkg::CNT_W'(1)
                                         : byte_count_q;
  assign psize    = (byte_count_q == '0) ? in_i.packet_byte : pending_size_q;
  assign pstart   = (byte_count_q == dmxfr_pkg::CNT_W'(1)) ? in_i.packet_byte
                                                           : pending_start_q;
  assign wr_en    = cmd_i.take_byte && (byte_count_q >= dmxfr_pkg::CNT_W'(2)) &&
                    (pay_off < MaxCh);
  assign wr_addr  = !active_bank_q ? dmxfr_pkg::ADDR_W'(MaxCh + pay_off)
                                   : dmxfr_pkg::ADDR_W'(pay_off);
  assign pkt_done = cmd_i.take_byte && in_i.packet_end;

  // Packet check, first failing rule wins
  always_comb begin
    if (len < dmxfr_pkg::CNT_W'(2) || len > MaxPkt) begin
      pkt_status = dmxfr_pkg::ST_BAD_LENGTH;
    end else if ({1'b0, psize} > MaxCh ||
                 {1'b0, psize} > len - dmxfr_pkg::CNT_W'(2)) begin
      pkt_status = dmxfr_pkg::ST_BAD_SIZE;
    end else if (pstart == 8'd0) begin
      pkt_status = dmxfr_pkg::ST_ZERO_START;
    end else begin
      pkt_status = dmxfr_pkg::ST_OK;
    end
  end

  // Read request check against the committed frame
  assign req_off = in_i.read_address - active_start_q;
  always_comb begin
    if (in_i.read_address == 8'd0) begin
      req_status = dmxfr_pkg::ST_ADDR_ZERO;
    end else if (active_size_q == 8'd0) begin
      req_status = dmxfr_pkg::ST_NO_FRAME;
    end else if (in_i.read_address < active_start_q) begin
      req_status = dmxfr_pkg::ST_BEFORE_START;
    end else if ({1'b0, req_off} + Slot > {1'b0, active_size_q}) begin
      req_status = dmxfr_pkg::ST_PAST_END;
    end else begin
      req_status = dmxfr_pkg::ST_OK;
    end
  end

  // Packet reception and commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_bank_q   <= 1'b0;
      active_size_q   <= '0;
      active_start_q  <= '0;
      pending_size_q  <= '0;
      pending_start_q <= '0;
      byte_count_q    <= '0;
    end else if (cmd_i.take_byte) begin
      pending_size_q  <= psize;
      pending_start_q <= pstart;
      byte_count_q    <= in_i.packet_end ? '0 : len;
      if (in_i.packet_end && pkt_status == dmxfr_pkg::ST_OK) begin
        active_bank_q  <= !active_bank_q;
        active_size_q  <= psize;
        active_start_q <= pstart;
      end
    end
  end

  // Read request latch and slot byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_status_q <= dmxfr_pkg::ST_OK;
      rd_base_q   <= '0;
      slot_k_q    <= '0;
    end else if (cmd_i.read_start) begin
      rd_status_q <= req_status;
      rd_base_q   <= active_bank_q ? dmxfr_pkg::ADDR_W'(MaxCh + {1'b0, req_off})
                                   : dmxfr_pkg::ADDR_W'(req_off);
      slot_k_q    <= '0;
    end else if (cmd_i.read_emit) begin
      slot_k_q    <= slot_k_q + dmxfr_pkg::SLOT_W'(1);
    end
  end

  assign rd_addr = rd_base_q + dmxfr_pkg::ADDR_W'(slot_k_q);

  // Frame store, both banks
  dmxfr_ram #(
    .WIDTH (8),
    .DEPTH (dmxfr_pkg::BANK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_i.packet_byte),
    .re_i    (cmd_i.read_issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pkt_done || cmd_i.read_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (pkt_done) begin
      out_kind_q   <= dmxfr_pkg::KIND_STATUS;
      out_status_q <= pkt_status;
      out_value_q  <= 8'd0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.read_emit) begin
      out_kind_q   <= dmxfr_pkg::KIND_SLOT;
      out_status_q <= rd_status_q;
      out_value_q  <= (rd_status_q == dmxfr_pkg::ST_OK) ? rd_data : 8'd0;
      out_last_q   <= status_o.slot_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.status     = out_status_q;
  assign out_o.value_byte = out_value_q;
  assign out_o.run_last   = out_last_q;

endmodule

[rtl/dmx_frame_receive_and_slot_read_core.sv]
// Top level of the DMX frame receiver and slot reader.
// Depends on dmxfr_pkg, dmxfr_in_if, dmxfr_out_if, dmxfr_ctrl and dmxfr_dp.
//
// A packet byte (mode 0) is taken whenever the controller is idle and the
// output register is free; the byte marked as the packet end puts one status
// beat into the output register in that same cycle. A slot read (mode 1)
// reads each slot byte from the frame store through its registered read port
// (state S_RD) and then loads it into the output register (state S_OUT),
// waiting there while the sink stalls; no new item is taken until the last
// slot byte is loaded. Both frame banks live in one 2 * MAX_CHANNELS byte RAM
// that needs no clearing after reset; a committed frame only ever reads bytes
// its packet wrote. Results leave through a single output register, so a
// stalled sink holds off the next input item.
module dmx_frame_receive_and_slot_read_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmxfr_in_if.sink    in_i,
  dmxfr_out_if.source out_o
);

  dmxfr_pkg::ctrl_cmd_t  cmd;
  dmxfr_pkg::dp_status_t dp_status;
  logic                  in_ready;

  assign in_i.ready = in_ready;

  dmxfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  dmxfr_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (dp_status)
  );

  // Input is only taken when the output register can take a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!out_o.valid || out_o.ready))
    else $error("input taken while output register blocked");

  // A status beat is always the only beat of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == dmxfr_pkg::KIND_STATUS) |->
      (out_o.run_last && out_o.value_byte == 8'd0))
    else $error("status beat with data or without last mark");

  // Failed reads carry zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == dmxfr_pkg::KIND_SLOT &&
     out_o.status != dmxfr_pkg::ST_OK) |-> (out_o.value_byte == 8'd0))
    else $error("failed slot read returned data");

  // Taking a slot read drops input ready, which stays low while its beats are read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.mode == dmxfr_pkg::MODE_READ) |=>
      !in_i.ready)
    else $error("input ready during slot read");

endmodule

[tb/dmx_frame_receive_and_slot_read_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for dmx_frame_receive_and_slot_read_core: directed rows, then random packets and reads.
// Each result beat is checked against an in-bench prediction of the frame store and slot reader.
// Depends on dmxfr_pkg, dmxfr_in_if, dmxfr_out_if and the core itself.
module dmx_frame_receive_and_slot_read_core_tb;
  import dmxfr_pkg::*;

  typedef enum logic {OP_PACKET, OP_READ} op_e;

  // One directed row: a whole packet or a single read
  typedef struct packed {
    op_e        op;
    logic [7:0] size_b;
    logic [7:0] start_b;
    logic [8:0] len;      // packet length in bytes, end mark on the last
    logic       mid;      // slip a read in after the size and start bytes
    logic [7:0] addr;     // read address (also for the slipped-in read)
    logic       pinned;   // status typed in below, no prediction needed
    logic [2:0] pin;
  } drow_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] value;
    logic       last;
  } beat_t;

  localparam int NROWS = 23;
  localparam drow_t DIRECTED [NROWS] = '{
    // reads right after reset
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd0,   1'b1, ST_ADDR_ZERO},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd1,   1'b1, ST_NO_FRAME},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd255, 1'b1, ST_NO_FRAME},
    // one-byte packet keeps the stale start byte, fails on length
    '{OP_PACKET, 8'd0,   8'd0,   9'd1,   1'b0, 8'd0,   1'b1, ST_BAD_LENGTH},
    // empty frame commits but still reads as no frame
    '{OP_PACKET, 8'd0,   8'd1,   9'd2,   1'b0, 8'd0,   1'b1, ST_OK},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd1,   1'b1, ST_NO_FRAME},
    // size checks, zero start
    '{OP_PACKET, 8'd255, 8'd1,   9'd10,  1'b0, 8'd0,   1'b1, ST_BAD_SIZE},
    '{OP_PACKET, 8'd5,   8'd1,   9'd6,   1'b0, 8'd0,   1'b1, ST_BAD_SIZE},
    '{OP_PACKET, 8'd4,   8'd0,   9'd6,   1'b0, 8'd0,   1'b1, ST_ZERO_START},
    // largest legal frame, read at both ends
    '{OP_PACKET, 8'd248, 8'd1,   9'd250, 1'b0, 8'd0,   1'b1, ST_OK},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd1,   1'b0, ST_OK},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd245, 1'b0, ST_OK},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd246, 1'b1, ST_PAST_END},
    // start at the top address, payload beyond size
    '{OP_PACKET, 8'd8,   8'd255, 9'd12,  1'b0, 8'd0,   1'b1, ST_OK},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd254, 1'b1, ST_BEFORE_START},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd255, 1'b0, ST_OK},
    // over-long packets: counter saturates, tail bytes must not spill
    '{OP_PACKET, 8'd10,  8'd1,   9'd251, 1'b0, 8'd0,   1'b1, ST_BAD_LENGTH},
    '{OP_PACKET, 8'd10,  8'd1,   9'd300, 1'b0, 8'd0,   1'b1, ST_BAD_LENGTH},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd255, 1'b0, ST_OK},
    // read in the middle of a packet sees the old frame
    '{OP_PACKET, 8'd4,   8'd10,  9'd6,   1'b1, 8'd255, 1'b0, ST_OK},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd10,  1'b0, ST_OK},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd11,  1'b1, ST_PAST_END},
    '{OP_READ,   8'd0,   8'd0,   9'd0,   1'b0, 8'd9,   1'b1, ST_BEFORE_START}
  };

  logic clk_i;
  logic rst_ni;

  dmxfr_in_if  in_if ();
  dmxfr_out_if out_if ();

  dmx_frame_receive_and_slot_read_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted frame store and receive state
  logic [7:0] bank_mem [BANK_DEPTH];
  logic       live_bank  = 1'b0;
  logic [7:0] live_size  = 8'd0;
  logic [7:0] live_start = 8'd0;
  logic [7:0] rx_size    = 8'd0;
  logic [7:0] rx_start   = 8'd0;
  logic [8:0] rx_count   = 9'd0;

  beat_t       due_beats [$];
  logic        pin_on = 1'b0;
  logic [2:0]  pin_st = ST_OK;
  int unsigned err_cnt = 0;
  int unsigned beats_in = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Work out the beats one accepted item causes and update the predicted state
  task automatic predict_beats(input logic mode, input logic [7:0] pbyte, input logic pend,
                               input logic [7:0] raddr);
    int unsigned idx;
    int unsigned len;
    int unsigned off;
    logic [2:0]  st;
    logic [7:0]  val;
    if (mode == MODE_PACKET) begin
      idx = rx_count;
      if (idx == 0) begin
        rx_size = pbyte;
      end else if (idx == 1) begin
        rx_start = pbyte;
      end else if (idx - 2 < MAX_CHANNELS) begin
        bank_mem[(live_bank ? 0 : MAX_CHANNELS) + idx - 2] = pbyte;
      end
      if (rx_count < COUNT_CAP) rx_count++;
      if (pend) begin
        len = rx_count;
        if (len < 2 || len > MAX_PACKET_BYTES) st = ST_BAD_LENGTH;
        else if (rx_size > MAX_CHANNELS || rx_size > len - 2) st = ST_BAD_SIZE;
        else if (rx_start == 8'd0) st = ST_ZERO_START;
        else begin
          st = ST_OK;
          live_bank  = ~live_bank;
          live_size  = rx_size;
          live_start = rx_start;
        end
        rx_count = 9'd0;
        due_beats.push_back({KIND_STATUS, pin_on ? pin_st : st, 8'h00, 1'b1});
      end
    end else begin
      st  = ST_OK;
      off = 0;
      if (raddr == 8'd0) st = ST_ADDR_ZERO;
      else if (live_size == 8'd0) st = ST_NO_FRAME;
      else if (raddr < live_start) st = ST_BEFORE_START;
      else begin
        off = raddr - live_start;
        if (off + SLOT_BYTES > live_size) st = ST_PAST_END;
      end
      if (pin_on) st = pin_st;
      for (int k = 0; k < SLOT_BYTES; k++) begin
        val = 8'h00;
        if (st == ST_OK && off + k < MAX_CHANNELS)
          val = bank_mem[(live_bank ? MAX_CHANNELS : 0) + off + k];
        due_beats.push_back({KIND_SLOT, st, val, k == SLOT_BYTES - 1});
      end
    end
  endtask

  // Offer one item, with random idle cycles first, and predict it once taken
  task automatic send_beat(input logic mode, input logic [7:0] pbyte, input logic pend,
                           input logic [7:0] raddr);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= mode;
    in_if.packet_byte  <= pbyte;
    in_if.packet_end   <= pend;
    in_if.read_address <= raddr;
    do @(posedge clk_i); while (!in_if.ready);
    beats_in++;
    predict_beats(mode, pbyte, pend, raddr);
  endtask

  // Size, start, payload; optionally a read slipped in before byte mid_at
  task automatic send_packet(input logic [7:0] size_b, input logic [7:0] start_b,
                             input int unsigned len, input int mid_at,
                             input logic [7:0] maddr);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if (mid_at == int'(i))
        send_beat(MODE_READ, 8'($urandom), 1'($urandom), maddr);
      b = (i == 0) ? size_b : (i == 1) ? start_b : 8'($urandom);
      send_beat(MODE_PACKET, b, i == len - 1, 8'($urandom));
    end
  endtask

  // Read addresses mostly aimed around the committed frame
  function automatic logic [7:0] pick_read_addr();
    int unsigned p;
    p = $urandom_range(99);
    if (live_size != 8'd0 && p < 70) return live_start + 8'($urandom_range(live_size));
    if (live_size != 8'd0 && p < 80) return live_start - 8'd1;
    return 8'($urandom_range(255));
  endfunction

  // Sink ready: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each output beat against the oldest prediction
  always @(posedge clk_i) begin : beat_check
    beat_t got;
    beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.kind, out_if.status, out_if.value_byte, out_if.run_last};
      if (due_beats.size() == 0) begin
        $display("%0t: beat with nothing expected, got %p", $time, got);
        err_cnt++;
      end else begin
        want = due_beats.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
          err_cnt++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          err_cnt++;
        end
        if (got.value !== want.value) begin
          $display("%0t: value_byte expected %0h, got %0h", $time, want.value, got.value);
          err_cnt++;
        end
        if (got.last !== want.last) begin
          $display("%0t: run_last expected %0d, got %0d", $time, want.last, got.last);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned n0;
    int unsigned sz;
    int unsigned len;
    int unsigned pick;
    int unsigned phase;
    logic [7:0]  st_b;
    bit          held;
    held = 1'b0;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.mode         <= MODE_PACKET;
    in_if.packet_byte  <= 8'd0;
    in_if.packet_end   <= 1'b0;
    in_if.read_address <= 8'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    for (int r = 0; r < NROWS; r++) begin
      pin_on = DIRECTED[r].pinned;
      pin_st = DIRECTED[r].pin;
      if (DIRECTED[r].op == OP_READ)
        send_beat(MODE_READ, 8'($urandom), 1'($urandom), DIRECTED[r].addr);
      else
        send_packet(DIRECTED[r].size_b, DIRECTED[r].start_b, DIRECTED[r].len,
                    DIRECTED[r].mid ? 2 : -1, DIRECTED[r].addr);
      pin_on = 1'b0;
    end

    // Random part, four idling phases
    n0 = beats_in;
    while (beats_in - n0 < 250) begin
      phase = (beats_in - n0) * 4 / 250;
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      // long sink hold-off while the sender keeps offering
      if (phase == 2 && !held) begin
        hold_req = 200;
        held = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        // well-formed packet, sometimes with a zero start, mostly small
        sz = ($urandom_range(99) < 3) ? $urandom_range(MAX_CHANNELS) : $urandom_range(12);
        st_b = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        len = sz + 2 + $urandom_range(2);
        if (len > MAX_PACKET_BYTES) len = MAX_PACKET_BYTES;
        send_packet(8'(sz), st_b, len,
                    ($urandom_range(9) == 0) ? int'($urandom_range(len - 1)) : -1,
                    pick_read_addr());
      end else if (pick < 85) begin
        send_beat(MODE_READ, 8'($urandom), 1'($urandom), pick_read_addr());
      end else begin
        // short or broken packet with arbitrary header
        send_packet(8'($urandom), 8'($urandom), $urandom_range(1, 6), -1, 8'd0);
      end
    end

    // Drain
    in_if.valid <= 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("dmx_frame_receive_and_slot_read_core_tb: done, clean");
    end else begin
      $display("dmx_frame_receive_and_slot_read_core_tb: done, errors");
    end
    $finish;
  end

  // Overall time limit
  initial begin
    #4_000_000;
    $display("dmx_frame_receive_and_slot_read_core_tb: done, errors");
    $finish;
  end

endmodule
